@@ rtl/core/scfc_pkg.sv @@
// Shared types, constants and the CRC-16 byte update for the sectioned frame checker.
`default_nettype none

package scfc_pkg;

  // File header length skipped before the first section
  localparam int unsigned FILE_HEADER_BYTES = 8;

  // CRC-16, MSB first, no reflection, no final XOR
  localparam logic [15:0] CRC_INIT = 16'h8320;
  localparam logic [15:0] CRC_POLY = 16'h1F45;

  // Configuration register reset values
  localparam logic        CHECK_LENGTHS_RST = 1'b1;
  localparam logic [15:0] MIN_LENGTH_RST    = 16'd32;
  localparam logic [31:0] MAX_LENGTH_RST    = 32'd65535;

  // Queue between front and back (power of two so the pointers wrap)
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Output stream packing
  localparam int unsigned OUT_DATA_W = 120;

  typedef enum logic [1:0] {
    CFG_CHECK_LENGTHS = 2'd0,
    CFG_MIN_LENGTH    = 2'd1,
    CFG_MAX_LENGTH    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_FILE_HDR = 2'd0,
    PH_SEC_HDR  = 2'd1,
    PH_BODY     = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_MATCH    = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_BAD_LEN  = 2'd2,
    ST_TRUNC    = 2'd3
  } status_e;

  // What the back end does with the running CRC for one byte
  typedef enum logic [1:0] {
    CRC_HOLD   = 2'd0,
    CRC_RESTART = 2'd1,
    CRC_UPDATE = 2'd2
  } crc_op_e;

  // Kind of report raised by one byte
  typedef enum logic [1:0] {
    EM_VERDICT   = 2'd0,
    EM_BAD_LEN   = 2'd1,
    EM_TRUNC_CRC = 2'd2,
    EM_TRUNC_HDR = 2'd3
  } emit_e;

  typedef struct packed {
    logic        check_lengths;
    logic [15:0] min_length_excl;
    logic [31:0] max_length;
  } cfg_t;

  // One classified byte, handed from front to back
  typedef struct packed {
    logic [7:0]  data_byte;
    crc_op_e     crc_op;
    logic        emit;
    emit_e       emit_kind;
    logic [31:0] offset;
    logic [31:0] stored;
    logic [31:0] length;
    logic        file_end;
  } op_t;

  // Advance the CRC by one byte, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/scfc_front.sv @@
// Front end: parses the byte stream and classifies each byte into a back-end operation.
`default_nettype none

module scfc_front #(
  parameter int unsigned FileHeaderBytes = scfc_pkg::FILE_HEADER_BYTES
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire scfc_pkg::cfg_t cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          last_byte_i,
  input  wire logic          queue_full_i,
  output logic               push_o,
  output scfc_pkg::op_t      op_o
);
  import scfc_pkg::*;

  localparam logic [31:0] HdrBytes = 32'(FileHeaderBytes);
  localparam phase_e PhaseStart = (FileHeaderBytes == 0) ? PH_SEC_HDR : PH_FILE_HDR;

  phase_e      phase_q, phase_d;
  logic [2:0]  idx_q, idx_d;
  logic [31:0] offset_q, offset_d;
  logic [31:0] length_q, length_d;
  logic [31:0] left_q, left_d;
  logic [31:0] stored_q, stored_d;
  logic [31:0] start_q, start_d;
  logic        halted_q, halted_d;

  logic        accept;
  logic [31:0] off_inc;
  logic [31:0] left_dec;
  logic [31:0] len_base, stored_base, shifted;
  logic [31:0] len_new, stored_new;
  logic        bad_len;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  // Section header field assembly
  assign off_inc     = offset_q + 32'd1;
  assign left_dec    = left_q - 32'd1;
  assign len_base    = (idx_q == 3'd0) ? 32'd0 : length_q;
  assign stored_base = (idx_q == 3'd0) ? 32'd0 : stored_q;
  assign shifted     = {24'd0, data_byte_i} << {idx_q[1:0], 3'b000};
  assign len_new     = idx_q[2] ? len_base : (len_base | shifted);
  assign stored_new  = idx_q[2] ? (stored_base | shifted) : stored_base;
  assign bad_len     = cfg_i.check_lengths &&
                       ((len_new <= {16'd0, cfg_i.min_length_excl}) ||
                        (len_new > cfg_i.max_length));

  // Next parse phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      if (!halted_q) begin
        case (phase_q)
          PH_FILE_HDR: begin
            if (off_inc >= HdrBytes) phase_d = PH_SEC_HDR;
          end
          PH_SEC_HDR: begin
            if ((idx_q == 3'd7) && !bad_len && (len_new != 32'd0)) phase_d = PH_BODY;
          end
          PH_BODY: begin
            if (left_dec == 32'd0) phase_d = PH_SEC_HDR;
          end
          default: phase_d = PH_SEC_HDR;
        endcase
      end
      if (last_byte_i) phase_d = PhaseStart;
    end
  end

  // Datapath updates and the operation handed to the back end
  always_comb begin
    idx_d    = idx_q;
    offset_d = offset_q;
    length_d = length_q;
    left_d   = left_q;
    stored_d = stored_q;
    start_d  = start_q;
    halted_d = halted_q;

    op_o.data_byte = data_byte_i;
    op_o.crc_op    = CRC_HOLD;
    op_o.emit      = 1'b0;
    op_o.emit_kind = EM_VERDICT;
    op_o.offset    = start_q;
    op_o.stored    = stored_q;
    op_o.length    = length_q;
    op_o.file_end  = last_byte_i;

    if (accept) begin
      offset_d = off_inc;
      if (!halted_q) begin
        case (phase_q)
          PH_SEC_HDR: begin
            length_d    = len_new;
            stored_d    = stored_new;
            op_o.stored = stored_new;
            op_o.length = len_new;
            if (idx_q == 3'd0) op_o.crc_op = CRC_RESTART;
            if (idx_q == 3'd7) begin
              idx_d       = 3'd0;
              start_d     = off_inc;
              op_o.offset = off_inc;
              if (bad_len) begin
                op_o.emit      = 1'b1;
                op_o.emit_kind = EM_BAD_LEN;
                halted_d       = 1'b1;
              end else if (len_new == 32'd0) begin
                op_o.emit      = 1'b1;
                op_o.emit_kind = EM_VERDICT;
              end else begin
                left_d         = len_new;
                op_o.emit      = last_byte_i;
                op_o.emit_kind = EM_TRUNC_CRC;
              end
            end else begin
              idx_d          = idx_q + 3'd1;
              op_o.offset    = offset_q + 32'(4'd8 - {1'b0, idx_q});
              op_o.emit      = last_byte_i;
              op_o.emit_kind = EM_TRUNC_HDR;
            end
          end
          PH_BODY: begin
            op_o.crc_op = CRC_UPDATE;
            left_d      = left_dec;
            if (left_dec == 32'd0) begin
              op_o.emit      = 1'b1;
              op_o.emit_kind = EM_VERDICT;
              idx_d          = 3'd0;
            end else begin
              op_o.emit      = last_byte_i;
              op_o.emit_kind = EM_TRUNC_CRC;
            end
          end
          default: begin
          end
        endcase
      end
      // Return to the start of a new file
      if (last_byte_i) begin
        idx_d    = 3'd0;
        offset_d = 32'd0;
        length_d = 32'd0;
        left_d   = 32'd0;
        stored_d = 32'd0;
        start_d  = 32'd0;
        halted_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhaseStart;
      idx_q    <= 3'd0;
      offset_q <= 32'd0;
      length_q <= 32'd0;
      left_q   <= 32'd0;
      stored_q <= 32'd0;
      start_q  <= 32'd0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      offset_q <= offset_d;
      length_q <= length_d;
      left_q   <= left_d;
      stored_q <= stored_d;
      start_q  <= start_d;
      halted_q <= halted_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/scfc_queue.sv @@
// Short queue of classified byte operations between front and back.
`default_nettype none

module scfc_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire scfc_pkg::op_t push_op_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output scfc_pkg::op_t      head_o
);
  import scfc_pkg::*;

  op_t                    slot_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;
  logic                   do_pop;

  assign full_o  = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Track fill level
  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) count_d = count_q + QUEUE_CNT_W'(1);
    else if (!push_i && do_pop) count_d = count_q - QUEUE_CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
      count_q <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_op_i;
  end

endmodule

`default_nettype wire

@@ rtl/core/scfc_back.sv @@
// Back end: runs the CRC-16 over body bytes and builds the section report.
`default_nettype none

module scfc_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           op_valid_i,
  input  wire scfc_pkg::op_t                  op_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [scfc_pkg::OUT_DATA_W-1:0]     out_data_o,
  output logic                                out_last_o
);
  import scfc_pkg::*;

  logic [15:0]            crc_q, crc_d;
  logic                   valid_q;
  logic [OUT_DATA_W-1:0]  data_q, data_d;
  logic                   last_q;
  logic                   slot_free;
  logic [15:0]            crc_out;
  status_e                status;

  assign slot_free = !valid_q || out_ready_i;
  assign pop_o     = op_valid_i && (!op_i.emit || slot_free);

  // Running CRC
  always_comb begin
    case (op_i.crc_op)
      CRC_RESTART: crc_d = CRC_INIT;
      CRC_UPDATE:  crc_d = crc_byte(crc_q, op_i.data_byte);
      default:     crc_d = crc_q;
    endcase
  end

  // Report value and status
  always_comb begin
    case (op_i.emit_kind)
      EM_VERDICT: begin
        crc_out = crc_d;
        status  = (op_i.stored == {16'd0, crc_d}) ? ST_MATCH : ST_MISMATCH;
      end
      EM_BAD_LEN: begin
        crc_out = 16'd0;
        status  = ST_BAD_LEN;
      end
      EM_TRUNC_CRC: begin
        crc_out = crc_d;
        status  = ST_TRUNC;
      end
      default: begin
        crc_out = CRC_INIT;
        status  = ST_TRUNC;
      end
    endcase
    data_d = {6'd0, status, op_i.length, crc_out, op_i.stored, op_i.offset};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CRC_INIT;
      valid_q <= 1'b0;
    end else begin
      if (pop_o) crc_q <= crc_d;
      if (pop_o && op_i.emit) valid_q <= 1'b1;
      else if (out_ready_i) valid_q <= 1'b0;
    end
  end

  // Hold the report until it is taken
  always_ff @(posedge clk_i) begin
    if (pop_o && op_i.emit) begin
      data_q <= data_d;
      last_q <= op_i.file_end;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

@@ rtl/core/sectioned_crc16_frame_checker.sv @@
// Top level of the sectioned CRC-16 frame checker: config registers, front, queue, back.
//
// Usage:
//   Bytes of a file enter on the s_axis channel, one per transfer, tlast on the
//   file's final byte. The block skips the file header, reads each section's
//   little-endian length and stored checksum words, runs CRC-16 (poly 0x1F45,
//   init 0x8320, MSB first) over the body and sends one report per section on
//   m_axis; tlast of a report marks that it came from the file's last byte.
//   Bad lengths and truncated files also give a report.
//   Registers are written on the cfg channel (index 0 check enable, 1 minimum
//   length, 2 maximum length); the user must write them only while no byte is
//   in flight, as the block itself does not enforce it. cfg_ready_o is always high.
//   Throughput is one byte per cycle unless the queue is full: the front parses
//   a byte per cycle and the back applies the unrolled eight-step CRC update
//   combinationally. The report of the deciding byte passes through the queue slot
//   and the output register before appearing on m_axis, later if the queue holds earlier bytes.
//   When the receiver stalls, the report waits in the output register while
//   the two-entry queue keeps taking bytes; s_axis_tready falls once it is full.
//   Reset returns parsing to the start of a file and restores register defaults;
//   no clearing pass is needed.
`default_nettype none

module sectioned_crc16_frame_checker #(
  parameter int unsigned FileHeaderBytes = scfc_pkg::FILE_HEADER_BYTES
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [1:0]                        cfg_index_i,
  input  wire logic [31:0]                       cfg_data_i,
  // Input byte stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [7:0]                        s_axis_tdata,   // [7:0] data_byte
  input  wire logic                              s_axis_tlast,   // last_byte
  // Section reports
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [31:0] section_offset, [63:32] stored_checksum, [79:64] computed_checksum,
  // [111:80] section_length, [113:112] status, [119:114] zero
  output logic [scfc_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  output logic                                   m_axis_tlast    // file_end
);
  import scfc_pkg::*;

  cfg_t cfg_q;
  logic queue_full, push, pop, head_valid;
  op_t  push_op, head_op;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.check_lengths   <= CHECK_LENGTHS_RST;
      cfg_q.min_length_excl <= MIN_LENGTH_RST;
      cfg_q.max_length      <= MAX_LENGTH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CHECK_LENGTHS: cfg_q.check_lengths   <= cfg_data_i[0];
        CFG_MIN_LENGTH:    cfg_q.min_length_excl <= cfg_data_i[15:0];
        CFG_MAX_LENGTH:    cfg_q.max_length      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  scfc_front #(
    .FileHeaderBytes(FileHeaderBytes)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .data_byte_i (s_axis_tdata),
    .last_byte_i (s_axis_tlast),
    .queue_full_i(queue_full),
    .push_o      (push),
    .op_o        (push_op)
  );

  scfc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .push_op_i(push_op),
    .full_o   (queue_full),
    .pop_i    (pop),
    .valid_o  (head_valid),
    .head_o   (head_op)
  );

  scfc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (head_valid),
    .op_i       (head_op),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ rtl/core/scfc_checker.sv @@
// Port-level checks on the section reports, bound to the top level.
`default_nettype none

module scfc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [scfc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                          m_axis_tlast
);
  import scfc_pkg::*;

  // A stalled report holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("report changed while stalled");

  // A bad length report carries a zero CRC
  a_bad_len_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[113:112] == ST_BAD_LEN) |-> (m_axis_tdata[79:64] == 16'd0))
    else $error("bad length report with nonzero CRC");

  // Truncation is only reported at the end of a file
  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[113:112] == ST_TRUNC) |-> m_axis_tlast)
    else $error("truncation report without file end");

  // A match means the stored word equals the CRC
  a_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[113:112] == ST_MATCH) |->
      (m_axis_tdata[63:48] == 16'd0) && (m_axis_tdata[47:32] == m_axis_tdata[79:64]))
    else $error("match reported for differing checksums");

endmodule

bind sectioned_crc16_frame_checker scfc_checker u_scfc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire
